// File: hdl/gcf_pkg.sv
package gcf_pkg;

    localparam int RATE_W     = 16;
    localparam int FLOW_W     = 16;
    localparam int DATA_W     = 24;
    localparam int COEF_W     = 24;
    localparam int NUM_COEF   = 4;
    localparam int COEF_SEL_W = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int PROD_W     = 2 * COEF_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int RND_SHIFT  = 16;
    localparam int COMP_W     = ACC_W - RND_SHIFT;
    localparam int Q8_SHIFT   = 8;
    localparam int WIDE_W     = 36;

    localparam logic OP_GYRO = 1'b0;
    localparam logic OP_FLOW = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_X0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y0 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END     = 4'd8;

    typedef logic signed [DATA_W-1:0] t_s24;

    typedef struct packed {
        logic                     opcode;
        logic signed [RATE_W-1:0] rate_x;
        logic signed [RATE_W-1:0] rate_y;
        logic signed [FLOW_W-1:0] flow_dx;
        logic signed [FLOW_W-1:0] flow_dy;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] clean_dx;
        logic signed [DATA_W-1:0] clean_dy;
    } t_out;

    localparam t_s24 COEF_X_RST [NUM_COEF] = '{
        24'sd10672, 24'sd52795, 24'sd73849, 24'sd59569
    };
    localparam t_s24 COEF_Y_RST [NUM_COEF] = '{
        -24'sd10914, 24'sd69070, 24'sd100214, 24'sd40430
    };

    localparam t_s24 BIAS_X = -24'sd27;
    localparam t_s24 BIAS_Y = -24'sd262;

    function automatic t_s24 sat24(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            return hi[DATA_W-1:0];
        end else if (v < lo) begin
            return lo[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

// File: hdl/gcf_axis.sv
module gcf_axis #(
    parameter int TAPS = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_adv,
    input  gcf_pkg::t_s24                        i_tap [TAPS],
    input  gcf_pkg::t_s24                        i_coef [TAPS],
    input  logic signed [gcf_pkg::FLOW_W-1:0]    i_flow,
    input  gcf_pkg::t_s24                        i_bias,
    output gcf_pkg::t_s24                        o_clean
);

    logic signed [gcf_pkg::PROD_W-1:0] r_prod [TAPS];
    logic signed [gcf_pkg::FLOW_W-1:0] r_flow2;
    logic signed [gcf_pkg::COMP_W-1:0] r_comp;
    logic signed [gcf_pkg::FLOW_W-1:0] r_flow3;
    gcf_pkg::t_s24                     r_clean;

    logic signed [gcf_pkg::ACC_W-1:0]  n_acc;
    logic signed [gcf_pkg::COMP_W-1:0] n_comp;
    logic signed [gcf_pkg::WIDE_W-1:0] n_flow_q8;
    logic signed [gcf_pkg::WIDE_W-1:0] n_diff;

    always_comb begin
        n_acc = '0;
        for (int k = 0; k < TAPS; k++) begin
            n_acc = n_acc + gcf_pkg::ACC_W'(r_prod[k]);
        end
        n_acc  = n_acc + (gcf_pkg::ACC_W'(1) <<< (gcf_pkg::RND_SHIFT - 1));
        n_comp = n_acc[gcf_pkg::ACC_W-1:gcf_pkg::RND_SHIFT];
    end

    always_comb begin
        n_flow_q8 = gcf_pkg::WIDE_W'(r_flow3) <<< gcf_pkg::Q8_SHIFT;
        n_diff    = n_flow_q8 - gcf_pkg::WIDE_W'(i_bias) - gcf_pkg::WIDE_W'(r_comp);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < TAPS; k++) begin
                r_prod[k] <= i_tap[k] * i_coef[k];
            end
            r_flow2 <= i_flow;
            r_comp  <= n_comp;
            r_flow3 <= r_flow2;
            r_clean <= gcf_pkg::sat24(n_diff);
        end
    end

    assign o_clean = r_clean;

endmodule

// File: hdl/gyro_compensated_flow_fir4.sv
// Gyro-compensated optical flow with a four-tap FIR per axis. A gyro transaction adds its
// rates into the saturating window sums and gives no result; a flow transaction pushes the
// window sums into the tap history, clears the windows and, at the end of the pipeline,
// presents the flow delta in Q.8 pixels with the rotation estimate removed. One
// transaction is accepted every cycle; the only stall comes from a held result on the output,
// which freezes the whole four-stage pipeline (history and flow register, multiply, sum and
// round, subtract and saturate).
// Coefficient writes are taken at any time and must only be made while the block is idle.
module gyro_compensated_flow_fir4 #(
    parameter int HISTORY_TAPS = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  gcf_pkg::t_in                       i_data,
    output logic                               o_valid,
    input  logic                               i_stall,
    output gcf_pkg::t_out                      o_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [gcf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gcf_pkg::COEF_W-1:0]         i_cfg_data
);

    localparam int ACT_TAPS = (HISTORY_TAPS < gcf_pkg::NUM_COEF) ?
                              HISTORY_TAPS : gcf_pkg::NUM_COEF;

    gcf_pkg::t_s24 r_coef_x [gcf_pkg::NUM_COEF];
    gcf_pkg::t_s24 r_coef_y [gcf_pkg::NUM_COEF];
    gcf_pkg::t_s24 r_win_x;
    gcf_pkg::t_s24 r_win_y;
    gcf_pkg::t_s24 r_hist_x [HISTORY_TAPS];
    gcf_pkg::t_s24 r_hist_y [HISTORY_TAPS];
    logic          r_v1;
    logic          r_v2;
    logic          r_v3;
    logic          r_ov;
    logic signed [gcf_pkg::FLOW_W-1:0] r_flow_x1;
    logic signed [gcf_pkg::FLOW_W-1:0] r_flow_y1;

    gcf_pkg::t_s24 n_win_x;
    gcf_pkg::t_s24 n_win_y;
    logic          w_adv;
    logic          w_acc;
    logic          w_flow;

    gcf_pkg::t_s24 w_tap_x  [ACT_TAPS];
    gcf_pkg::t_s24 w_tap_y  [ACT_TAPS];
    gcf_pkg::t_s24 w_coef_x [ACT_TAPS];
    gcf_pkg::t_s24 w_coef_y [ACT_TAPS];

    assign w_adv       = !(r_ov && i_stall);
    assign o_stall     = r_ov && i_stall;
    assign w_acc       = i_valid && w_adv;
    assign w_flow      = i_data.opcode == gcf_pkg::OP_FLOW;
    assign o_valid     = r_ov;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_win_x = gcf_pkg::sat24(gcf_pkg::WIDE_W'(r_win_x) + gcf_pkg::WIDE_W'(i_data.rate_x));
        n_win_y = gcf_pkg::sat24(gcf_pkg::WIDE_W'(r_win_y) + gcf_pkg::WIDE_W'(i_data.rate_y));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_x <= gcf_pkg::COEF_X_RST;
            r_coef_y <= gcf_pkg::COEF_Y_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index < gcf_pkg::CFG_COEF_Y0) begin
                r_coef_x[i_cfg_index[gcf_pkg::COEF_SEL_W-1:0]] <= i_cfg_data;
            end else if (i_cfg_index < gcf_pkg::CFG_END) begin
                r_coef_y[i_cfg_index[gcf_pkg::COEF_SEL_W-1:0]] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_x <= '0;
            r_win_y <= '0;
            for (int i = 0; i < HISTORY_TAPS; i++) begin
                r_hist_x[i] <= '0;
                r_hist_y[i] <= '0;
            end
        end else if (w_acc) begin
            if (w_flow) begin
                r_win_x     <= '0;
                r_win_y     <= '0;
                r_hist_x[0] <= r_win_x;
                r_hist_y[0] <= r_win_y;
                for (int i = 1; i < HISTORY_TAPS; i++) begin
                    r_hist_x[i] <= r_hist_x[i-1];
                    r_hist_y[i] <= r_hist_y[i-1];
                end
            end else begin
                r_win_x <= n_win_x;
                r_win_y <= n_win_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid && w_flow;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ov <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_flow_x1 <= i_data.flow_dx;
            r_flow_y1 <= i_data.flow_dy;
        end
    end

    // The history registers only change on an accepted transaction, so the multiply stage
    // reads the history left by the flow transaction that sits in the first stage.
    for (genvar k = 0; k < ACT_TAPS; k++) begin : g_tap
        assign w_tap_x[k]  = r_hist_x[k];
        assign w_tap_y[k]  = r_hist_y[k];
        assign w_coef_x[k] = r_coef_x[k];
        assign w_coef_y[k] = r_coef_y[k];
    end

    gcf_axis #(
        .TAPS    (ACT_TAPS)
    ) u_axis_x (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_tap   (w_tap_x),
        .i_coef  (w_coef_x),
        .i_flow  (r_flow_x1),
        .i_bias  (gcf_pkg::BIAS_X),
        .o_clean (o_data.clean_dx)
    );

    gcf_axis #(
        .TAPS    (ACT_TAPS)
    ) u_axis_y (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_tap   (w_tap_y),
        .i_coef  (w_coef_y),
        .i_flow  (r_flow_y1),
        .i_bias  (gcf_pkg::BIAS_Y),
        .o_clean (o_data.clean_dy)
    );

    a_gyro_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_flow) |=> !r_v1)
        else $error("gyro transaction entered the result pipeline");

    a_flow_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_flow) |=> r_v1)
        else $error("flow transaction did not enter the result pipeline");

    a_flow_clears_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_flow) |=> (r_win_x == '0 && r_win_y == '0))
        else $error("window sums not cleared by flow transaction");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled without a pending result");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam longint S24_HI   = 64'sd8388607;
    localparam longint S24_LO   = -64'sd8388608;
    localparam int     LAT_PAD  = 10;
    localparam int     SAT_RUN  = 260;
    localparam int     PHASE_N  = 45;

    typedef enum int {CS_UNIT, CS_MAX, CS_MIN, CS_ZERO, CS_SMALL, CS_FULL} t_coef_set;

    class t_flow_scoreboard;
        gcf_pkg::t_s24   coef_x[gcf_pkg::NUM_COEF];
        gcf_pkg::t_s24   coef_y[gcf_pkg::NUM_COEF];
        gcf_pkg::t_s24   win_x;
        gcf_pkg::t_s24   win_y;
        gcf_pkg::t_s24   hist_x[gcf_pkg::NUM_COEF];
        gcf_pkg::t_s24   hist_y[gcf_pkg::NUM_COEF];
        gcf_pkg::t_out   clean_flow_q[$];
        int              errors;
        int              results_seen;
        int              gyro_items;
        int              flow_items;

        function new();
            for (int k = 0; k < gcf_pkg::NUM_COEF; k++) begin
                coef_x[k] = gcf_pkg::COEF_X_RST[k];
                coef_y[k] = gcf_pkg::COEF_Y_RST[k];
                hist_x[k] = '0;
                hist_y[k] = '0;
            end
            win_x = '0;
            win_y = '0;
        endfunction

        function gcf_pkg::t_s24 sat_s24(longint v);
            if (v > S24_HI) begin
                return gcf_pkg::t_s24'(S24_HI);
            end else if (v < S24_LO) begin
                return gcf_pkg::t_s24'(S24_LO);
            end
            return gcf_pkg::t_s24'(v);
        endfunction

        function void set_coef(logic [gcf_pkg::CFG_IDX_W-1:0] idx,
                               logic [gcf_pkg::COEF_W-1:0] val);
            if (idx < gcf_pkg::CFG_COEF_Y0) begin
                coef_x[idx - gcf_pkg::CFG_COEF_X0] = val;
            end else if (idx < gcf_pkg::CFG_END) begin
                coef_y[idx - gcf_pkg::CFG_COEF_Y0] = val;
            end
        endfunction

        function gcf_pkg::t_s24 axis_clean(bit y_axis, logic signed [gcf_pkg::FLOW_W-1:0] flow);
            longint acc;
            longint comp;
            longint bias;
            acc = 0;
            for (int k = 0; k < gcf_pkg::NUM_COEF; k++) begin
                if (y_axis) begin
                    acc += longint'(coef_y[k]) * longint'(hist_y[k]);
                end else begin
                    acc += longint'(coef_x[k]) * longint'(hist_x[k]);
                end
            end
            comp = (acc + 64'sd32768) >>> gcf_pkg::RND_SHIFT;
            bias = y_axis ? longint'(gcf_pkg::BIAS_Y) : longint'(gcf_pkg::BIAS_X);
            return sat_s24(longint'($signed(flow)) * 256 - (bias + comp));
        endfunction

        function void note_item(gcf_pkg::t_in it);
            gcf_pkg::t_out want;
            if (it.opcode == gcf_pkg::OP_GYRO) begin
                gyro_items++;
                win_x = sat_s24(longint'(win_x) + longint'($signed(it.rate_x)));
                win_y = sat_s24(longint'(win_y) + longint'($signed(it.rate_y)));
            end else begin
                flow_items++;
                for (int k = gcf_pkg::NUM_COEF - 1; k > 0; k--) begin
                    hist_x[k] = hist_x[k-1];
                    hist_y[k] = hist_y[k-1];
                end
                hist_x[0] = win_x;
                hist_y[0] = win_y;
                win_x = '0;
                win_y = '0;
                want.clean_dx = axis_clean(1'b0, it.flow_dx);
                want.clean_dy = axis_clean(1'b1, it.flow_dy);
                clean_flow_q.push_back(want);
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) begin
                $display("MISMATCH at %0t: %s", $time, msg);
            end
        endtask

        task check_clean_flow(gcf_pkg::t_out got);
            gcf_pkg::t_out want;
            results_seen++;
            if (clean_flow_q.size() == 0) begin
                report($sformatf("result %0d (dx=%0d dy=%0d) arrived with none expected",
                                 results_seen, got.clean_dx, got.clean_dy));
                return;
            end
            want = clean_flow_q.pop_front();
            if (got.clean_dx !== want.clean_dx) begin
                report($sformatf("result %0d clean_dx got %0d expected %0d",
                                 results_seen, got.clean_dx, want.clean_dx));
            end
            if (got.clean_dy !== want.clean_dy) begin
                report($sformatf("result %0d clean_dy got %0d expected %0d",
                                 results_seen, got.clean_dy, want.clean_dy));
            end
        endtask

        function int pending();
            return clean_flow_q.size();
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_stall;
    gcf_pkg::t_in                    i_data;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    gcf_pkg::t_out                   o_data;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [gcf_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [gcf_pkg::COEF_W-1:0]      i_cfg_data;

    t_flow_scoreboard sb = new();
    bit               gaps_on = 1'b0;
    int               stall_left = 0;
    int               items_sent = 0;
    int               settings_used = 0;
    gcf_pkg::t_s24    next_cx[gcf_pkg::NUM_COEF];
    gcf_pkg::t_s24    next_cy[gcf_pkg::NUM_COEF];

    gyro_compensated_flow_fir4 uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 4);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_clean_flow(o_data);
        end
    end

    task automatic send_item(gcf_pkg::t_in it);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_gyro(logic signed [gcf_pkg::RATE_W-1:0] rx,
                             logic signed [gcf_pkg::RATE_W-1:0] ry);
        gcf_pkg::t_in it;
        it.opcode = gcf_pkg::OP_GYRO;
        it.rate_x = rx;
        it.rate_y = ry;
        it.flow_dx = gcf_pkg::FLOW_W'($urandom);
        it.flow_dy = gcf_pkg::FLOW_W'($urandom);
        send_item(it);
    endtask

    task automatic send_flow(logic signed [gcf_pkg::FLOW_W-1:0] fx,
                             logic signed [gcf_pkg::FLOW_W-1:0] fy);
        gcf_pkg::t_in it;
        it.opcode = gcf_pkg::OP_FLOW;
        it.rate_x = gcf_pkg::RATE_W'($urandom);
        it.rate_y = gcf_pkg::RATE_W'($urandom);
        it.flow_dx = fx;
        it.flow_dy = fy;
        send_item(it);
    endtask

    function automatic logic signed [gcf_pkg::RATE_W-1:0] pick_value(bit narrow);
        case ($urandom_range(0, 15))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return narrow ? gcf_pkg::RATE_W'($urandom_range(0, 2047) - 1024)
                                   : gcf_pkg::RATE_W'($urandom);
        endcase
    endfunction

    task automatic send_random_window();
        int            n;
        bit            narrow;
        gcf_pkg::t_in  junk;
        n = $urandom_range(0, 24);
        narrow = 1'($urandom_range(0, 1));
        repeat (n) begin
            if ($urandom_range(0, 9) == 0) begin
                junk.opcode = 1'($urandom);
                junk.rate_x = gcf_pkg::RATE_W'($urandom);
                junk.rate_y = gcf_pkg::RATE_W'($urandom);
                junk.flow_dx = gcf_pkg::FLOW_W'($urandom);
                junk.flow_dy = gcf_pkg::FLOW_W'($urandom);
                send_item(junk);
            end else begin
                send_gyro(pick_value(narrow), pick_value(narrow));
            end
        end
        send_flow(pick_value(1'($urandom_range(0, 1))), pick_value(1'($urandom_range(0, 1))));
    endtask

    task automatic send_saturating_window(bit x_up);
        repeat (SAT_RUN) send_gyro(x_up ? 16'h7FFF : 16'h8000, x_up ? 16'h8000 : 16'h7FFF);
        repeat (4) send_flow(pick_value(1'b0), pick_value(1'b0));
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (LAT_PAD) @(negedge i_clk);
    endtask

    task automatic write_coef(logic [gcf_pkg::CFG_IDX_W-1:0] idx,
                              logic [gcf_pkg::COEF_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_coef(idx, val);
        @(negedge i_clk);
    endtask

    task automatic load_setting(t_coef_set kind);
        for (int k = 0; k < gcf_pkg::NUM_COEF; k++) begin
            case (kind)
                CS_UNIT: begin
                    next_cx[k] = (k == 0) ? 24'sd1 : 24'sd0;
                    next_cy[k] = (k == 0) ? -24'sd1 : 24'sd0;
                end
                CS_MAX: begin
                    next_cx[k] = 24'h7FFFFF;
                    next_cy[k] = 24'h7FFFFF;
                end
                CS_MIN: begin
                    next_cx[k] = 24'h800000;
                    next_cy[k] = 24'h800000;
                end
                CS_ZERO: begin
                    next_cx[k] = '0;
                    next_cy[k] = '0;
                end
                CS_SMALL: begin
                    next_cx[k] = gcf_pkg::COEF_W'($urandom_range(0, 1 << 18) - (1 << 17));
                    next_cy[k] = gcf_pkg::COEF_W'($urandom_range(0, 1 << 18) - (1 << 17));
                end
                default: begin
                    next_cx[k] = gcf_pkg::COEF_W'($urandom);
                    next_cy[k] = gcf_pkg::COEF_W'($urandom);
                    if ($urandom_range(0, 3) == 0) begin
                        next_cx[k] = 24'h7FFFFF;
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        next_cy[k] = 24'h800000;
                    end
                end
            endcase
        end
        for (int k = 0; k < gcf_pkg::NUM_COEF; k++) begin
            write_coef(gcf_pkg::CFG_IDX_W'(gcf_pkg::CFG_COEF_X0 + k), next_cx[k]);
            write_coef(gcf_pkg::CFG_IDX_W'(gcf_pkg::CFG_COEF_Y0 + k), next_cy[k]);
        end
        // Indexes past the last register must leave every weight untouched.
        write_coef(gcf_pkg::CFG_IDX_W'(gcf_pkg::CFG_END + $urandom_range(0, 7)),
                   gcf_pkg::COEF_W'($urandom));
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial begin
        t_coef_set plan[6];
        int        start;
        plan = '{CS_MAX, CS_MIN, CS_ZERO, CS_SMALL, CS_FULL, CS_SMALL};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        gaps_on = 1'b1;

        // Reset weights: empty history, saturation at both ends, tiny deltas.
        send_flow(16'sd0, 16'sd0);
        send_gyro(16'h7FFF, 16'h7FFF);
        send_flow(16'h8000, 16'h7FFF);
        send_gyro(16'h8000, 16'h8000);
        send_gyro(16'h8000, 16'h8000);
        send_flow(16'h7FFF, 16'h8000);
        send_flow(16'sd1, -16'sd1);
        send_flow(-16'sd1, 16'sd1);
        send_gyro(16'sd1, -16'sd1);
        send_flow(16'sd0, 16'sd0);

        // Unit weight on the newest tap exposes the half-up rounding.
        wait_idle();
        load_setting(CS_UNIT);
        send_gyro(16'h8000, 16'h8000);
        send_flow(16'sd0, 16'sd0);
        send_gyro(16'sd16384, 16'sd16384);
        send_gyro(16'sd16384, 16'sd16384);
        send_flow(16'sd0, 16'sd0);
        send_gyro(16'h7FFF, 16'h7FFF);
        send_flow(16'sd0, 16'sd0);
        send_gyro(16'h8000, 16'h7FFF);
        send_gyro(-16'sd1, 16'sd0);
        send_flow(16'sd0, 16'sd0);

        for (int p = 0; p < 6; p++) begin
            wait_idle();
            load_setting(plan[p]);
            start = items_sent;
            gaps_on = (p != 5);
            if (p == 3) begin
                send_saturating_window(1'b1);
            end
            while (items_sent - start < PHASE_N) begin
                gaps_on = (p != 5) && ($urandom_range(0, 3) != 0);
                send_random_window();
            end
        end
        wait_idle();

        $display("Sent %0d transactions (%0d gyro, %0d flow) under %0d weight settings.",
                 items_sent, sb.gyro_items, sb.flow_items, settings_used + 1);
        $display("Compared %0d results, including window and output saturation runs.",
                 sb.results_seen);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Timed out with %0d results still expected.", sb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
